[hdl/tdmm_pkg.sv]
// Shared types and constants for the tridiagonal matrix multiply stream.
// Holds the request and result payload structs and the product bundle between stages.
// No dependencies.
package tdmm_pkg;

    // Line buffer depth and derived widths
    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int WORD_W     = 2 * COEF_W;
    localparam int COLCNT_W   = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

    // One input request
    typedef struct packed {
        logic signed [COEF_W-1:0] rhs_value;
        logic signed [COEF_W-1:0] super_coef;
        logic signed [COEF_W-1:0] main_coef;
        logic signed [COEF_W-1:0] sub_coef;
    } t_in_item;

    // One result
    typedef struct packed {
        logic signed [SUM_W-1:0] out_value;
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic                    last;
    } t_out_item;

    // Products of one request, handed to the result sequencer
    typedef struct packed {
        logic signed [PROD_W-1:0] a_main;
        logic signed [PROD_W-1:0] a_super;
        logic signed [PROD_W-1:0] a_sub;
        logic signed [PROD_W-1:0] b_main;
        logic signed [PROD_W-1:0] b_sub;
        logic                     has_a;
        logic                     has_b;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
    } t_prod;

endpackage

[hdl/tridiagonal_matrix_multiply_stream.sv]
// Top level of the tridiagonal matrix times dense matrix stream.
// Depends on tdmm_pkg, tdmm_line_buf and tdmm_result_seq.
//
// Takes one request per cycle unless the output stalls, and gives the result
// for row r, column c when element (r+1, c) arrives; on a matrix's last row each
// request gives two results (when more than one row), so requests there wait on
// the output register, which moves one result at a time. The first result of a
// request passes the read stage and the output register. The two previous rows
// live in a single 1024 x 32 synchronous line buffer, read when a request is
// taken and written back as it leaves the read stage; a back-to-back request to
// the same column gets the written-back word forwarded. Line buffer contents are
// not cleared after reset: the first two rows of the first matrix fill them.
module tridiagonal_matrix_multiply_stream (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tdmm_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tdmm_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [tdmm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdmm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration and position
    logic [tdmm_pkg::ROW_W-1:0]     r_row_count;
    logic [tdmm_pkg::COLCNT_W-1:0]  r_col_count;
    logic [tdmm_pkg::ROW_W-1:0]     r_row_ctr;
    logic [tdmm_pkg::COL_W-1:0]     r_col_ctr;
    logic [tdmm_pkg::COEF_W-1:0]    r_held_super;
    logic [tdmm_pkg::COEF_W-1:0]    r_held_main;
    logic [tdmm_pkg::COEF_W-1:0]    r_held_sub;

    // Read stage
    logic                           r_s1_valid;
    tdmm_pkg::t_in_item             r_s1_item;
    logic [tdmm_pkg::COEF_W-1:0]    r_s1_hsup;
    logic [tdmm_pkg::COEF_W-1:0]    r_s1_hmain;
    logic [tdmm_pkg::COEF_W-1:0]    r_s1_hsub;
    logic [tdmm_pkg::ROW_W-1:0]     r_s1_row;
    logic [tdmm_pkg::COL_W-1:0]     r_s1_col;
    logic                           r_s1_last_row;
    logic                           r_s1_fwd;
    logic [tdmm_pkg::WORD_W-1:0]    r_s1_fwd_word;

    logic [tdmm_pkg::ROW_W-1:0]     w_m_eff;
    logic [tdmm_pkg::COLCNT_W-1:0]  w_n_eff;
    logic                           w_last_row;
    logic                           w_last_col;
    logic                           w_accept;
    logic                           w_s1_adv;
    logic                           w_prod_ready;
    logic [tdmm_pkg::WORD_W-1:0]    w_mem_q;
    logic [tdmm_pkg::WORD_W-1:0]    w_s1_word;
    logic [tdmm_pkg::WORD_W-1:0]    w_s1_wr_word;
    logic signed [tdmm_pkg::COEF_W-1:0] w_xp;
    logic signed [tdmm_pkg::COEF_W-1:0] w_xc;
    logic signed [tdmm_pkg::COEF_W-1:0] w_a_sub_op;
    logic signed [tdmm_pkg::COEF_W-1:0] w_b_sub_op;
    tdmm_pkg::t_prod                w_prod;

    // Clamp the register values to their working range
    assign w_m_eff = (r_row_count == '0) ? tdmm_pkg::ROW_W'(1) : r_row_count;
    assign w_n_eff = (r_col_count == '0) ? tdmm_pkg::COLCNT_W'(1) :
                     (r_col_count > tdmm_pkg::COLCNT_W'(tdmm_pkg::MAX_COLS)) ?
                     tdmm_pkg::COLCNT_W'(tdmm_pkg::MAX_COLS) : r_col_count;
    assign w_last_row = ({1'b0, r_row_ctr} + 17'd1) >= {1'b0, w_m_eff};
    assign w_last_col = ({1'b0, r_col_ctr} + tdmm_pkg::COLCNT_W'(1)) >= w_n_eff;

    assign w_s1_adv   = r_s1_valid && w_prod_ready;
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= tdmm_pkg::ROW_W'(1);
            r_col_count <= tdmm_pkg::COLCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tdmm_pkg::REG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data;
                end
                tdmm_pkg::REG_COL_COUNT: begin
                    r_col_count <= i_cfg_data[tdmm_pkg::COLCNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Advance position; hold the coefficients of a finished row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ctr    <= '0;
            r_col_ctr    <= '0;
            r_held_super <= '0;
            r_held_main  <= '0;
            r_held_sub   <= '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col_ctr    <= '0;
                r_row_ctr    <= w_last_row ? '0 : r_row_ctr + tdmm_pkg::ROW_W'(1);
                r_held_super <= i_in_item.super_coef;
                r_held_main  <= i_in_item.main_coef;
                r_held_sub   <= i_in_item.sub_coef;
            end else begin
                r_col_ctr <= r_col_ctr + tdmm_pkg::COL_W'(1);
            end
        end
    end

    // Read stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture the request; forward a same-column write-back of this edge
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item     <= i_in_item;
            r_s1_hsup     <= r_held_super;
            r_s1_hmain    <= r_held_main;
            r_s1_hsub     <= r_held_sub;
            r_s1_row      <= r_row_ctr;
            r_s1_col      <= r_col_ctr;
            r_s1_last_row <= w_last_row;
            r_s1_fwd      <= w_s1_adv && (r_s1_col == r_col_ctr);
            r_s1_fwd_word <= w_s1_wr_word;
        end
    end

    tdmm_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col_ctr),
        .o_rd_data (w_mem_q),
        .i_wr_en   (w_s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_s1_wr_word)
    );

    // Shift the column's rows down: the current row moves to previous
    assign w_s1_word    = r_s1_fwd ? r_s1_fwd_word : w_mem_q;
    assign w_xp         = w_s1_word[tdmm_pkg::WORD_W-1:tdmm_pkg::COEF_W];
    assign w_xc         = w_s1_word[tdmm_pkg::COEF_W-1:0];
    assign w_s1_wr_word = {w_xc, r_s1_item.rhs_value};

    // Drop the sub term on a matrix's first row
    assign w_a_sub_op = (r_s1_row[tdmm_pkg::ROW_W-1:1] != '0) ? r_s1_hsub : '0;
    assign w_b_sub_op = (r_s1_row != '0) ? r_s1_item.sub_coef : '0;

    // Products for the delayed result (a) and the same-row result (b)
    always_comb begin
        w_prod.a_main  = $signed(r_s1_hmain) * w_xc;
        w_prod.a_super = $signed(r_s1_hsup) * r_s1_item.rhs_value;
        w_prod.a_sub   = w_a_sub_op * w_xp;
        w_prod.b_main  = r_s1_item.main_coef * r_s1_item.rhs_value;
        w_prod.b_sub   = w_b_sub_op * w_xc;
        w_prod.has_a   = r_s1_row != '0;
        w_prod.has_b   = r_s1_last_row;
        w_prod.row     = r_s1_row;
        w_prod.col     = r_s1_col;
    end

    tdmm_result_seq u_result_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prod_valid (r_s1_valid),
        .o_prod_ready (w_prod_ready),
        .i_prod       (w_prod),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

[hdl/tdmm_line_buf.sv]
// Line buffer RAM: per column, the right-hand-side values of the two previous rows.
// One synchronous read port with registered data, one write port.
// Depends on tdmm_pkg.
module tdmm_line_buf (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [tdmm_pkg::COL_W-1:0]    i_rd_addr,
    output logic [tdmm_pkg::WORD_W-1:0]   o_rd_data,
    input  logic                          i_wr_en,
    input  logic [tdmm_pkg::COL_W-1:0]    i_wr_addr,
    input  logic [tdmm_pkg::WORD_W-1:0]   i_wr_data
);

    logic [tdmm_pkg::WORD_W-1:0] mem [tdmm_pkg::MAX_COLS];
    logic [tdmm_pkg::WORD_W-1:0] r_rd_data;

    // Read old contents; a same-edge write lands after the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/tdmm_result_seq.sv]
// Result sequencer: holds the products of one request, sums them and
// issues one or two results through the output register. Depends on tdmm_pkg.
module tdmm_result_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_prod_valid,
    output logic                  o_prod_ready,
    input  tdmm_pkg::t_prod       i_prod,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tdmm_pkg::t_out_item   o_out_item
);

    logic                       r_s2_valid;
    logic                       r_a_done;
    tdmm_pkg::t_prod            r_s2;
    logic                       r_out_valid;
    tdmm_pkg::t_out_item        r_out_item;

    logic                       w_out_free;
    logic                       w_pend_a;
    logic                       w_any;
    logic                       w_final_emit;
    logic                       w_s2_done;
    logic                       w_emit;
    logic                       w_load;
    logic signed [tdmm_pkg::SUM_W-1:0] w_sum_a;
    logic signed [tdmm_pkg::SUM_W-1:0] w_sum_b;

    // Work out which result goes next and when the held request is finished
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_pend_a     = r_s2.has_a && !r_a_done;
    assign w_any        = w_pend_a || r_s2.has_b;
    assign w_final_emit = w_pend_a ? !r_s2.has_b : 1'b1;
    assign w_s2_done    = r_s2_valid && (!w_any || (w_out_free && w_final_emit));
    assign w_emit       = r_s2_valid && w_any && w_out_free;
    assign o_prod_ready = !r_s2_valid || w_s2_done;
    assign w_load       = i_prod_valid && o_prod_ready;

    // Exact sums, sign-extended to the result width
    assign w_sum_a = {r_s2.a_main[tdmm_pkg::PROD_W-1], r_s2.a_main}
                   + {r_s2.a_super[tdmm_pkg::PROD_W-1], r_s2.a_super}
                   + {r_s2.a_sub[tdmm_pkg::PROD_W-1], r_s2.a_sub};
    assign w_sum_b = {r_s2.b_main[tdmm_pkg::PROD_W-1], r_s2.b_main}
                   + {r_s2.b_sub[tdmm_pkg::PROD_W-1], r_s2.b_sub};

    // Hold the product bundle and track the first result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_a_done   <= 1'b0;
        end else if (w_load) begin
            r_s2_valid <= 1'b1;
            r_a_done   <= 1'b0;
        end else if (w_s2_done) begin
            r_s2_valid <= 1'b0;
        end else if (w_emit) begin
            r_a_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s2 <= i_prod;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item.out_value <= w_pend_a ? w_sum_a : w_sum_b;
            r_out_item.out_row   <= w_pend_a ? r_s2.row - tdmm_pkg::ROW_W'(1) : r_s2.row;
            r_out_item.out_col   <= r_s2.col;
            r_out_item.last      <= w_final_emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hdl/tdmm_checker.sv]
// Port-level checks for the tridiagonal matrix multiply stream.
// Bound to the top level below; depends on tdmm_pkg.
module tdmm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input tdmm_pkg::t_out_item                 o_out_item
);

    logic                         r_pair_pend;
    logic [tdmm_pkg::ROW_W-1:0]   r_pair_row;
    logic [tdmm_pkg::COL_W-1:0]   r_pair_col;

    // Remember the first result of a pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_pend <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_pair_pend <= !o_out_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            r_pair_row <= o_out_item.out_row;
            r_pair_col <= o_out_item.out_col;
        end
    end

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // The second result of a pair is the next row of the same column
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair_pend && o_out_valid |->
            o_out_item.last
            && (o_out_item.out_row == r_pair_row + tdmm_pkg::ROW_W'(1))
            && (o_out_item.out_col == r_pair_col))
        else $error("second result of a pair is out of place");

    // The first result of a pair always has a row below it
    a_pair_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> o_out_item.out_row != '1)
        else $error("first result of a pair on an impossible row");

endmodule

bind tridiagonal_matrix_multiply_stream tdmm_checker u_tdmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

[tb/sv/tdmm_product_checker.sv]
// Scoreboard for the tridiagonal matrix multiply stream: watches the request,
// result and register channels, predicts every result and compares it.
// Depends on tdmm_pkg for the payload types and register indexes.
module tdmm_product_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  tdmm_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  tdmm_pkg::t_out_item             i_out_item,
    input  logic                            i_cfg_we,
    input  logic [tdmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tdmm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    // Shadow registers and line buffers of the block
    logic [tdmm_pkg::ROW_W-1:0]         row_count_reg;
    logic [tdmm_pkg::COLCNT_W-1:0]      col_count_reg;
    logic signed [tdmm_pkg::COEF_W-1:0] older_rhs [tdmm_pkg::MAX_COLS];
    logic signed [tdmm_pkg::COEF_W-1:0] newer_rhs [tdmm_pkg::MAX_COLS];
    logic signed [tdmm_pkg::COEF_W-1:0] kept_super;
    logic signed [tdmm_pkg::COEF_W-1:0] kept_main;
    logic signed [tdmm_pkg::COEF_W-1:0] kept_sub;
    logic [tdmm_pkg::COL_W-1:0]         next_col;
    logic [tdmm_pkg::ROW_W-1:0]         next_row;
    tdmm_pkg::t_out_item                expected_products [$];
    int                                 mismatches = 0;

    // Work out the products caused by one request and advance the position
    task automatic predict_products(input tdmm_pkg::t_in_item req);
        int                                 rows_eff;
        int                                 cols_eff;
        logic                               end_of_row;
        logic                               end_of_block;
        logic signed [tdmm_pkg::COEF_W-1:0] x_two_back;
        logic signed [tdmm_pkg::COEF_W-1:0] x_one_back;
        longint                             acc;
        tdmm_pkg::t_out_item                delayed;
        tdmm_pkg::t_out_item                own;

        rows_eff = (row_count_reg == '0) ? 1 : int'(row_count_reg);
        if (col_count_reg == '0) begin
            cols_eff = 1;
        end else if (int'(col_count_reg) > tdmm_pkg::MAX_COLS) begin
            cols_eff = tdmm_pkg::MAX_COLS;
        end else begin
            cols_eff = int'(col_count_reg);
        end
        end_of_row   = int'(next_col) >= cols_eff - 1;
        end_of_block = int'(next_row) >= rows_eff - 1;
        x_two_back   = older_rhs[next_col];
        x_one_back   = newer_rhs[next_col];

        // Result of the previous row, now that its lower neighbour is here
        if (next_row != '0) begin
            acc = longint'(kept_main) * longint'(x_one_back)
                + longint'(kept_super) * longint'(req.rhs_value);
            if (next_row != tdmm_pkg::ROW_W'(1)) begin
                acc += longint'(kept_sub) * longint'(x_two_back);
            end
            delayed.out_value = acc[tdmm_pkg::SUM_W-1:0];
            delayed.out_row   = next_row - tdmm_pkg::ROW_W'(1);
            delayed.out_col   = next_col;
            delayed.last      = !end_of_block;
            expected_products.push_back(delayed);
        end

        // Result of the block's last row, using this request's own coefficients
        if (end_of_block) begin
            acc = longint'(req.main_coef) * longint'(req.rhs_value);
            if (next_row != '0) begin
                acc += longint'(req.sub_coef) * longint'(x_one_back);
            end
            own.out_value = acc[tdmm_pkg::SUM_W-1:0];
            own.out_row   = next_row;
            own.out_col   = next_col;
            own.last      = 1'b1;
            expected_products.push_back(own);
        end

        // Shift the column through the line buffers
        older_rhs[next_col] = x_one_back;
        newer_rhs[next_col] = req.rhs_value;

        // Advance the position; coefficients are kept from the row's last column
        if (end_of_row) begin
            kept_super = req.super_coef;
            kept_main  = req.main_coef;
            kept_sub   = req.sub_coef;
            next_col   = '0;
            next_row   = end_of_block ? '0 : next_row + tdmm_pkg::ROW_W'(1);
        end else begin
            next_col = next_col + tdmm_pkg::COL_W'(1);
        end
    endtask

    // Compare one result with the oldest prediction
    task automatic check_product(input tdmm_pkg::t_out_item got);
        tdmm_pkg::t_out_item want;

        if (expected_products.size() == 0) begin
            $error("unexpected result: row %0d col %0d value %0d",
                   got.out_row, got.out_col, $signed(got.out_value));
            mismatches++;
        end else begin
            want = expected_products.pop_front();
            if (got.out_value !== want.out_value) begin
                $error("out_value: expected %0d, actual %0d",
                       $signed(want.out_value), $signed(got.out_value));
                mismatches++;
            end
            if (got.out_row !== want.out_row) begin
                $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
                mismatches++;
            end
            if (got.out_col !== want.out_col) begin
                $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    // Track registers, requests and results at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_count_reg = tdmm_pkg::ROW_W'(1);
            col_count_reg = tdmm_pkg::COLCNT_W'(1);
            kept_super    = '0;
            kept_main     = '0;
            kept_sub      = '0;
            next_col      = '0;
            next_row      = '0;
            for (int i = 0; i < tdmm_pkg::MAX_COLS; i++) begin
                older_rhs[i] = '0;
                newer_rhs[i] = '0;
            end
            expected_products.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == tdmm_pkg::REG_ROW_COUNT) begin
                    row_count_reg = i_cfg_data[tdmm_pkg::ROW_W-1:0];
                end else if (i_cfg_index == tdmm_pkg::REG_COL_COUNT) begin
                    col_count_reg = i_cfg_data[tdmm_pkg::COLCNT_W-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_products(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                check_product(i_out_item);
            end
        end
        o_pending    <= expected_products.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/sv/tb_tridiagonal_matrix_multiply_stream.sv]
// Top of the testbench: clock, reset, register writes and request stimulus,
// with randomly stalled results. Depends on tdmm_pkg, the block itself and
// tdmm_product_checker, which predicts and compares every result.
module tb_tridiagonal_matrix_multiply_stream;

    localparam int RANDOM_REQUESTS = 700;
    localparam int IDLE_PCT        = 14;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int CALM_FROM       = 200;
    localparam int CALM_TO         = 500;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    tdmm_pkg::t_in_item              in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    tdmm_pkg::t_out_item             out_item;
    logic                            cfg_we    = 1'b0;
    logic [tdmm_pkg::CFG_IDX_W-1:0]  cfg_index = tdmm_pkg::REG_ROW_COUNT;
    logic [tdmm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            calm      = 1'b0;
    int                              fail_count;
    int                              results_pending;
    int                              requests_sent = 0;
    int                              random_base;
    int                              cycle_count   = 0;
    int                              rows_pick;
    int                              cols_pick;

    tridiagonal_matrix_multiply_stream dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tdmm_product_checker product_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    always #5 clk = ~clk;

    // Stall the result side at random, except during the calm stretch
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Field value biased towards the corners
    function automatic logic [15:0] random_field();
        case ($urandom_range(0, 11))
            0:       random_field = 16'h8000;
            1:       random_field = 16'h7FFF;
            2:       random_field = 16'h0000;
            3:       random_field = 16'hFFFF;
            default: random_field = 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic tdmm_pkg::t_in_item make_request(input logic [15:0] x,
                                                        input logic [15:0] sup,
                                                        input logic [15:0] mn,
                                                        input logic [15:0] sb);
        tdmm_pkg::t_in_item req;
        req.rhs_value  = x;
        req.super_coef = sup;
        req.main_coef  = mn;
        req.sub_coef   = sb;
        return req;
    endfunction

    // Present one request, with random idle cycles ahead of it
    task automatic send_request(input tdmm_pkg::t_in_item req);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            in_item  <= tdmm_pkg::t_in_item'({$urandom, $urandom});
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            send_request(make_request(random_field(), random_field(),
                                      random_field(), random_field()));
        end
    endtask

    // Drop valid and hold until every result is in and the pipeline is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [tdmm_pkg::CFG_DATA_W-1:0] rows,
                              input logic [tdmm_pkg::CFG_DATA_W-1:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= tdmm_pkg::REG_ROW_COUNT;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= tdmm_pkg::REG_COL_COUNT;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Reset sizes: single-row, single-column blocks, main term only
        send_request(make_request(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_request(make_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_request(make_request(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_request(make_request(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(make_request(16'h0001, 16'h5A5A, 16'hFFFF, 16'hA5A5));

        // Three-row blocks: largest positive then largest negative sums
        wait_idle();
        set_config(16'd3, 16'd2);
        repeat (6) send_request(make_request(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        repeat (6) send_request(make_request(16'h7FFF, 16'h8000, 16'h8000, 16'h8000));

        // Zero sizes act as one
        wait_idle();
        set_config(16'd0, 16'd0);
        send_random(3);

        // Two-row blocks: nothing on the first row, two results on the second
        wait_idle();
        set_config(16'd2, 16'd3);
        send_random(6);

        // Oversized column count clamps to the buffer depth; then shrink mid-row
        wait_idle();
        set_config(16'd2, 16'd2047);
        send_random(tdmm_pkg::MAX_COLS + 3);
        wait_idle();
        set_config(16'd2, 16'd3);
        send_random(1);

        // Full column count, then shrink below the column counter
        wait_idle();
        set_config(16'd1, 16'd1024);
        send_random(5);
        wait_idle();
        set_config(16'd1, 16'd2);
        send_random(1);

        // Largest row count, then shrink below the row counter
        wait_idle();
        set_config(16'd65535, 16'd2);
        send_random(6);
        wait_idle();
        set_config(16'd2, 16'd2);
        send_random(2);

        // Random sizes, whole blocks per setting
        random_base = requests_sent;
        while (requests_sent < random_base + RANDOM_REQUESTS) begin
            calm <= (requests_sent - random_base >= CALM_FROM) &&
                    (requests_sent - random_base < CALM_TO);
            case ($urandom_range(0, 9))
                0:       rows_pick = 0;
                1:       rows_pick = 1;
                8, 9:    rows_pick = $urandom_range(7, 12);
                default: rows_pick = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       cols_pick = 0;
                1:       cols_pick = 1;
                8, 9:    cols_pick = $urandom_range(9, 16);
                default: cols_pick = $urandom_range(2, 8);
            endcase
            wait_idle();
            set_config(tdmm_pkg::CFG_DATA_W'(rows_pick), tdmm_pkg::CFG_DATA_W'(cols_pick));
            send_random((rows_pick == 0 ? 1 : rows_pick) * (cols_pick == 0 ? 1 : cols_pick)
                        * $urandom_range(1, 4));
        end

        calm <= 1'b0;
        wait_idle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/tdmm_pkg.sv
hdl/tdmm_line_buf.sv
hdl/tdmm_result_seq.sv
hdl/tridiagonal_matrix_multiply_stream.sv
hdl/tdmm_checker.sv
tb/sv/tdmm_product_checker.sv
tb/sv/tb_tridiagonal_matrix_multiply_stream.sv
